/* sv/bbc_pkg.sv */
// Shared types, cause codes and character decode for the bracket balance checker.
`timescale 1ns / 1ps

package bbc_pkg;

  // Cause codes carried in fault_cause
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_MISMATCH = 3'd1;
  localparam logic [2:0] CAUSE_EMPTY    = 3'd2;
  localparam logic [2:0] CAUSE_UNCLOSED = 3'd3;
  localparam logic [2:0] CAUSE_OVERFLOW = 3'd4;

  // Bracket kinds as stored on the stack
  localparam logic [1:0] KIND_PAREN   = 2'd0;
  localparam logic [1:0] KIND_BRACE   = 2'd1;
  localparam logic [1:0] KIND_ANGLE   = 2'd2;
  localparam logic [1:0] KIND_SQUARE  = 2'd3;

  // ASCII codes of the brackets
  localparam logic [7:0] CHR_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CHR_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CHR_OPEN_BRACE   = 8'h7B;
  localparam logic [7:0] CHR_CLOSE_BRACE  = 8'h7D;
  localparam logic [7:0] CHR_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CHR_CLOSE_ANGLE  = 8'h3E;
  localparam logic [7:0] CHR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHR_CLOSE_SQUARE = 8'h5D;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] cause_t;

  // Decoded character
  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } char_class_t;

  // Stage handed from the stack stage to the verdict stage
  typedef struct packed {
    logic   valid;
    logic   last;      // beat carried the end mark
    logic   popped;    // closer popped an entry, read data is live
    kind_t  kind;      // kind of the closer
    cause_t fault;     // overflow or empty-stack fault found at the stack
    logic   count_nz;  // stack not empty after this beat's push or pop
  } stage_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '0;
    case (c)
      CHR_OPEN_PAREN:   begin r.is_open  = 1'b1; r.kind = KIND_PAREN;  end
      CHR_OPEN_BRACE:   begin r.is_open  = 1'b1; r.kind = KIND_BRACE;  end
      CHR_OPEN_ANGLE:   begin r.is_open  = 1'b1; r.kind = KIND_ANGLE;  end
      CHR_OPEN_SQUARE:  begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
      CHR_CLOSE_PAREN:  begin r.is_close = 1'b1; r.kind = KIND_PAREN;  end
      CHR_CLOSE_BRACE:  begin r.is_close = 1'b1; r.kind = KIND_BRACE;  end
      CHR_CLOSE_ANGLE:  begin r.is_close = 1'b1; r.kind = KIND_ANGLE;  end
      CHR_CLOSE_SQUARE: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
      default:          r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/bbc_in_if.sv */
// Input channel: one text byte and its end mark per beat.
`timescale 1ns / 1ps

interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* sv/bbc_out_if.sv */
// Output channel: one verdict per text.
`timescale 1ns / 1ps

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       is_balanced;
  logic [2:0] fault_cause;

  modport source (output valid, output is_balanced, output fault_cause, input ready);
  modport sink   (input valid, input is_balanced, input fault_cause, output ready);
endinterface

/* sv/bracket_balance_checker.sv */
// The end-mark beat is held in the stage register, then its verdict in the output register until taken.
// Throughput: one byte per cycle unless a verdict stalls; each beat does one push or one pop on the kind
// memory, and a pop's read data is checked in the following stage, so beats follow back to back.
// Reset: synchronous, clears the fill count, first fault and stage/output valids.
// The kind memory is not cleared; only entries pushed in the current text are read.
`timescale 1ns / 1ps

module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  bbc_in_if.sink     bytes,
  bbc_out_if.source  verdict
);

  bbc_pkg::stage_t stage;
  bbc_pkg::kind_t  rd_kind;
  logic            take;

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .take    (take),
    .stage   (stage),
    .rd_kind (rd_kind)
  );

  bbc_verdict u_verdict (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .rd_kind (rd_kind),
    .take    (take),
    .verdict (verdict)
  );

endmodule

/* sv/bbc_stack.sv */
// Stack stage: decodes each byte, keeps the fill count and pushes or pops the kind memory.
`timescale 1ns / 1ps

module bbc_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  bbc_in_if.sink           bytes,
  input  logic             take,      // verdict stage consumes the held stage
  output bbc_pkg::stage_t  stage,
  output bbc_pkg::kind_t   rd_kind
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);

  // Kind memory, synchronous read into a register
  bbc_pkg::kind_t mem [STACK_DEPTH];

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_op;
  logic [CW-1:0]        count_m1;
  bbc_pkg::char_class_t cls;
  logic                 accept;
  logic                 push_ok;
  logic                 pop_ok;
  bbc_pkg::cause_t      fault;

  // Decode and stack bounds
  always_comb begin
    cls      = bbc_pkg::classify(bytes.text_byte);
    push_ok  = cls.is_open && (count != DEPTH_CNT);
    pop_ok   = cls.is_close && (count != '0);
    count_m1 = count - CW'(1);
    if (cls.is_open && !push_ok) begin
      fault = bbc_pkg::CAUSE_OVERFLOW;
    end else if (cls.is_close && !pop_ok) begin
      fault = bbc_pkg::CAUSE_EMPTY;
    end else begin
      fault = bbc_pkg::CAUSE_NONE;
    end
    if (push_ok) begin
      count_op = count + CW'(1);
    end else if (pop_ok) begin
      count_op = count_m1;
    end else begin
      count_op = count;
    end
  end

  // Take a new beat when the stage is free or being drained
  assign bytes.ready = !stage.valid || take;
  assign accept      = bytes.valid && bytes.ready;

  // Fill count, cleared after the end mark
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= bytes.end_of_text ? '0 : count_op;
    end
  end

  // Push writes at the fill count, pop reads just below it
  always_ff @(posedge clk) begin
    if (accept && push_ok) begin
      mem[count[AW-1:0]] <= cls.kind;
    end
    if (accept && pop_ok) begin
      rd_kind <= mem[count_m1[AW-1:0]];
    end
  end

  // Stage register toward the verdict logic
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.last     <= bytes.end_of_text;
      stage.popped   <= pop_ok;
      stage.kind     <= cls.kind;
      stage.fault    <= fault;
      stage.count_nz <= (count_op != '0);
    end
  end

endmodule

/* sv/bbc_verdict.sv */
// Verdict stage: checks popped kinds, holds the first fault and registers the result.
`timescale 1ns / 1ps

module bbc_verdict (
  input  logic             clk,
  input  logic             rst,
  input  bbc_pkg::stage_t  stage,
  input  bbc_pkg::kind_t   rd_kind,
  output logic             take,
  bbc_out_if.source        verdict
);

  bbc_pkg::cause_t first_fault;
  bbc_pkg::cause_t fault_now;
  bbc_pkg::cause_t cause;
  logic            out_valid;
  logic            out_balanced;
  bbc_pkg::cause_t out_cause;

  // Fault of this beat and the cause it would report
  always_comb begin
    if (stage.fault != bbc_pkg::CAUSE_NONE) begin
      fault_now = stage.fault;
    end else if (stage.popped && (rd_kind != stage.kind)) begin
      fault_now = bbc_pkg::CAUSE_MISMATCH;
    end else begin
      fault_now = bbc_pkg::CAUSE_NONE;
    end
    if (first_fault != bbc_pkg::CAUSE_NONE) begin
      cause = first_fault;
    end else if (fault_now != bbc_pkg::CAUSE_NONE) begin
      cause = fault_now;
    end else if (stage.count_nz) begin
      cause = bbc_pkg::CAUSE_UNCLOSED;
    end else begin
      cause = bbc_pkg::CAUSE_NONE;
    end
  end

  // Only an end beat waits on the output register
  assign take = stage.valid && (!stage.last || !out_valid || verdict.ready);

  // First fault wins, cleared at the end mark
  always_ff @(posedge clk) begin
    if (rst) begin
      first_fault <= bbc_pkg::CAUSE_NONE;
    end else if (take) begin
      if (stage.last) begin
        first_fault <= bbc_pkg::CAUSE_NONE;
      end else if (first_fault == bbc_pkg::CAUSE_NONE) begin
        first_fault <= fault_now;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && stage.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.last) begin
      out_balanced <= (cause == bbc_pkg::CAUSE_NONE);
      out_cause    <= cause;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.is_balanced = out_balanced;
  assign verdict.fault_cause = out_cause;

endmodule

/* sv/bbc_checker.sv */
// Port-level assertions for the bracket balance checker and their bind.
`timescale 1ns / 1ps

module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_balanced,
  input logic [2:0] fault_cause
);

  // A waiting verdict stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // Balanced flag agrees with the cause code
  a_flag_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_balanced == (fault_cause == bbc_pkg::CAUSE_NONE)))
    else $error("is_balanced disagrees with fault_cause");

  // Only defined cause codes leave the block
  a_cause_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fault_cause <= bbc_pkg::CAUSE_OVERFLOW))
    else $error("undefined fault cause");

  // No verdict and an open input right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("activity right after reset");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (bytes.ready),
  .out_valid   (verdict.valid),
  .out_ready   (verdict.ready),
  .is_balanced (verdict.is_balanced),
  .fault_cause (verdict.fault_cause)
);
